// File: sv/rpbu_pkg.sv
// ----------------------------------------------------------------------------
// rpbu_pkg
// Shared constants for the RGB pixel blend unit: mode codes, register
// indexes, channel codes, reset values and the divide-by-255 reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

package rpbu_pkg;

    localparam int unsigned ChanW    = 8;
    localparam int unsigned NumChan  = 3;
    localparam int unsigned ModeW    = 4;
    localparam int unsigned SelW     = 2;
    localparam int unsigned AmountW  = 9;
    localparam int unsigned FactorW  = 8;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 9;
    localparam int unsigned TermW    = 16;
    localparam int unsigned RecipW   = 17;
    localparam int unsigned RecipSh  = 24;
    localparam int unsigned ProdW    = TermW + RecipW;

    typedef logic [NumChan-1:0][ChanW-1:0] t_pix;

    localparam logic [ModeW-1:0] MODE_MUL      = 4'd0;
    localparam logic [ModeW-1:0] MODE_SCREEN   = 4'd1;
    localparam logic [ModeW-1:0] MODE_SUB      = 4'd2;
    localparam logic [ModeW-1:0] MODE_ADD      = 4'd3;
    localparam logic [ModeW-1:0] MODE_OVERLAY  = 4'd4;
    localparam logic [ModeW-1:0] MODE_COMBINE  = 4'd5;
    localparam logic [ModeW-1:0] MODE_ONLY_R   = 4'd6;
    localparam logic [ModeW-1:0] MODE_ONLY_G   = 4'd7;
    localparam logic [ModeW-1:0] MODE_ONLY_B   = 4'd8;
    localparam logic [ModeW-1:0] MODE_ADD_CH   = 4'd9;
    localparam logic [ModeW-1:0] MODE_SCALE_CH = 4'd10;

    localparam logic [CfgIdxW-1:0] REG_BLEND_MODE     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CHANNEL_SELECT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ADD_AMOUNT     = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SCALE_FACTOR   = 2'd3;

    localparam logic [SelW-1:0] CH_BLUE  = 2'd0;
    localparam logic [SelW-1:0] CH_GREEN = 2'd1;
    localparam logic [SelW-1:0] CH_RED   = 2'd2;

    localparam logic [ModeW-1:0]   RST_BLEND_MODE     = MODE_MUL;
    localparam logic [SelW-1:0]    RST_CHANNEL_SELECT = CH_RED;
    localparam logic [AmountW-1:0] RST_ADD_AMOUNT     = 9'd0;
    localparam logic [FactorW-1:0] RST_SCALE_FACTOR   = 8'd1;

    localparam logic [ChanW-1:0]  CHAN_MAX   = 8'd255;
    localparam logic [TermW-1:0]  ROUND_HALF = 16'd127;
    // ceil(2^24 / 255); exact floor division for terms below 66052.
    localparam logic [RecipW-1:0] RECIP_255  = 17'd65794;

endpackage

`default_nettype wire

// File: sv/rgb_pixel_blend_unit.sv
// An accepted input item passes the stage-one, stage-two and output registers.
// Throughput: one item per cycle when i_stall is low; the stage-two reciprocal multiplier is the
// deepest path and every stage holds one item.
// Reset clears all stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// rgb_pixel_blend_unit
// Three-stage pixel blender: operand product, divide by 255 through a
// reciprocal multiply, then inversion and result selection.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_blend_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rpbu_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire logic [rpbu_pkg::CfgDataW-1:0]     i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [rpbu_pkg::ChanW-1:0]        i_a_blue,
    input  wire logic [rpbu_pkg::ChanW-1:0]        i_a_green,
    input  wire logic [rpbu_pkg::ChanW-1:0]        i_a_red,
    input  wire logic [rpbu_pkg::ChanW-1:0]        i_b_blue,
    input  wire logic [rpbu_pkg::ChanW-1:0]        i_b_green,
    input  wire logic [rpbu_pkg::ChanW-1:0]        i_b_red,
    input  wire logic [rpbu_pkg::ChanW-1:0]        i_c_blue,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [rpbu_pkg::ChanW-1:0]             o_out_blue,
    output logic [rpbu_pkg::ChanW-1:0]             o_out_green,
    output logic [rpbu_pkg::ChanW-1:0]             o_out_red
);

    logic [rpbu_pkg::ModeW-1:0]   r_blend_mode;
    logic [rpbu_pkg::SelW-1:0]    r_channel_select;
    logic [rpbu_pkg::AmountW-1:0] r_add_amount;
    logic [rpbu_pkg::FactorW-1:0] r_scale_factor;

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    rpbu_pkg::t_pix                                    r_s1_simple, n_s1_simple;
    logic [rpbu_pkg::NumChan-1:0][rpbu_pkg::TermW-1:0] r_s1_term, n_s1_term;
    logic [rpbu_pkg::NumChan-1:0]                      r_s1_inv, n_s1_inv;
    logic                                              r_s1_use_div, n_s1_use_div;

    rpbu_pkg::t_pix               r_s2_simple, r_s2_quot, n_s2_quot;
    logic [rpbu_pkg::NumChan-1:0] r_s2_inv;
    logic                         r_s2_use_div;

    rpbu_pkg::t_pix r_s3_out, n_s3_out;

    rpbu_pkg::t_pix pix_a, pix_b;

    assign pix_a = {i_a_red, i_a_green, i_a_blue};
    assign pix_b = {i_b_red, i_b_green, i_b_blue};

    assign en3 = !r_v3 || !i_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_stall     = !en1;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_v3;
    assign o_out_blue  = r_s3_out[0];
    assign o_out_green = r_s3_out[1];
    assign o_out_red   = r_s3_out[2];

    // Stage one: operand selection, 8x8 products and simple modes (saturating add, sub and channel adjust).
    always_comb begin
        logic [rpbu_pkg::ChanW-1:0]   opp, opq, av, bv, adj;
        logic [rpbu_pkg::TermW-1:0]   prod, scaled;
        logic                         dbl;
        logic signed [10:0]           sum_s;
        logic [rpbu_pkg::ChanW:0]     sum_u;

        n_s1_use_div = (r_blend_mode == rpbu_pkg::MODE_MUL) ||
                       (r_blend_mode == rpbu_pkg::MODE_SCREEN) ||
                       (r_blend_mode == rpbu_pkg::MODE_OVERLAY);
        for (int c = 0; c < rpbu_pkg::NumChan; c++) begin
            av  = pix_a[c];
            bv  = pix_b[c];
            opp = '0;
            opq = '0;
            dbl = 1'b0;
            n_s1_inv[c] = 1'b0;
            case (r_blend_mode)
                rpbu_pkg::MODE_MUL: begin
                    opp = av;
                    opq = bv;
                end
                rpbu_pkg::MODE_SCREEN: begin
                    opp = ~av;
                    opq = ~bv;
                    n_s1_inv[c] = 1'b1;
                end
                rpbu_pkg::MODE_OVERLAY: begin
                    dbl = 1'b1;
                    if (bv[rpbu_pkg::ChanW-1]) begin
                        opp = ~av;
                        opq = ~bv;
                        n_s1_inv[c] = 1'b1;
                    end else begin
                        opp = av;
                        opq = bv;
                    end
                end
                default: begin
                    opp = '0;
                    opq = '0;
                end
            endcase
            prod = rpbu_pkg::TermW'(opp) * rpbu_pkg::TermW'(opq);
            n_s1_term[c] = (dbl ? {prod[rpbu_pkg::TermW-2:0], 1'b0} : prod) +
                           rpbu_pkg::ROUND_HALF;

            sum_s  = $signed({3'b000, av}) +
                     $signed({{2{r_add_amount[rpbu_pkg::AmountW-1]}}, r_add_amount});
            scaled = rpbu_pkg::TermW'(av) * rpbu_pkg::TermW'(r_scale_factor);
            if (r_blend_mode == rpbu_pkg::MODE_ADD_CH) begin
                if (sum_s[10]) begin
                    adj = '0;
                end else if (sum_s[9:8] != 2'b00) begin
                    adj = rpbu_pkg::CHAN_MAX;
                end else begin
                    adj = sum_s[7:0];
                end
            end else begin
                adj = (scaled[rpbu_pkg::TermW-1:rpbu_pkg::ChanW] != '0) ?
                      rpbu_pkg::CHAN_MAX : scaled[rpbu_pkg::ChanW-1:0];
            end
            sum_u = {1'b0, av} + {1'b0, bv};

            case (r_blend_mode)
                rpbu_pkg::MODE_SUB: begin
                    n_s1_simple[c] = (av >= bv) ? (av - bv) : '0;
                end
                rpbu_pkg::MODE_ADD: begin
                    n_s1_simple[c] = sum_u[rpbu_pkg::ChanW] ? rpbu_pkg::CHAN_MAX
                                                            : sum_u[rpbu_pkg::ChanW-1:0];
                end
                rpbu_pkg::MODE_COMBINE: begin
                    n_s1_simple[c] = (c == 0) ? i_c_blue : (c == 1) ? i_b_green : i_a_red;
                end
                rpbu_pkg::MODE_ONLY_R: begin
                    n_s1_simple[c] = i_a_red;
                end
                rpbu_pkg::MODE_ONLY_G: begin
                    n_s1_simple[c] = i_a_green;
                end
                rpbu_pkg::MODE_ONLY_B: begin
                    n_s1_simple[c] = i_a_blue;
                end
                rpbu_pkg::MODE_ADD_CH, rpbu_pkg::MODE_SCALE_CH: begin
                    n_s1_simple[c] = (r_channel_select == rpbu_pkg::SelW'(c)) ? adj : av;
                end
                default: begin
                    n_s1_simple[c] = av;
                end
            endcase
        end
    end

    // Stage two: floor division by 255 as a reciprocal multiply.
    always_comb begin
        logic [rpbu_pkg::ProdW-1:0] q_prod;
        for (int c = 0; c < rpbu_pkg::NumChan; c++) begin
            q_prod = rpbu_pkg::ProdW'(r_s1_term[c]) * rpbu_pkg::ProdW'(rpbu_pkg::RECIP_255);
            n_s2_quot[c] = q_prod[rpbu_pkg::RecipSh +: rpbu_pkg::ChanW];
        end
    end

    // Stage three: inversion for screen and upper overlay, then selection.
    always_comb begin
        for (int c = 0; c < rpbu_pkg::NumChan; c++) begin
            if (r_s2_use_div) begin
                n_s3_out[c] = r_s2_inv[c] ? ~r_s2_quot[c] : r_s2_quot[c];
            end else begin
                n_s3_out[c] = r_s2_simple[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode     <= rpbu_pkg::RST_BLEND_MODE;
            r_channel_select <= rpbu_pkg::RST_CHANNEL_SELECT;
            r_add_amount     <= rpbu_pkg::RST_ADD_AMOUNT;
            r_scale_factor   <= rpbu_pkg::RST_SCALE_FACTOR;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_v3             <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rpbu_pkg::REG_BLEND_MODE: begin
                        r_blend_mode <= i_cfg_data[rpbu_pkg::ModeW-1:0];
                    end
                    rpbu_pkg::REG_CHANNEL_SELECT: begin
                        r_channel_select <= i_cfg_data[rpbu_pkg::SelW-1:0];
                    end
                    rpbu_pkg::REG_ADD_AMOUNT: begin
                        r_add_amount <= i_cfg_data[rpbu_pkg::AmountW-1:0];
                    end
                    rpbu_pkg::REG_SCALE_FACTOR: begin
                        r_scale_factor <= i_cfg_data[rpbu_pkg::FactorW-1:0];
                    end
                    default: begin
                        r_blend_mode <= r_blend_mode;
                    end
                endcase
            end
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_simple  <= n_s1_simple;
            r_s1_term    <= n_s1_term;
            r_s1_inv     <= n_s1_inv;
            r_s1_use_div <= n_s1_use_div;
        end
        if (en2) begin
            r_s2_simple  <= r_s1_simple;
            r_s2_quot    <= n_s2_quot;
            r_s2_inv     <= r_s1_inv;
            r_s2_use_div <= r_s1_use_div;
        end
        if (en3) begin
            r_s3_out <= n_s3_out;
        end
    end

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && i_stall))
        else $error("input stalled while the pipeline has a free stage");

    a_stage2_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3) |=> r_v3)
        else $error("item lost between stage two and the output register");

    a_stage1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && en2) |=> r_v2)
        else $error("item lost between stage one and stage two");

    a_reset_regs: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_blend_mode == rpbu_pkg::RST_BLEND_MODE &&
                      r_scale_factor == rpbu_pkg::RST_SCALE_FACTOR && !r_v3))
        else $error("registers not at reset values after reset");

endmodule

`default_nettype wire
